>>> src/mam_pkg.sv
// Package for the modular arithmetic unit.
// Opcodes, fixed widths and the control struct of the serial step cell.
// No dependencies.
package mam_pkg;
	localparam int RAW_WIDTH = 64;
	localparam int MOD_RESET = 10007;

	localparam logic [2:0] OP_RED = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_MUL = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_POW = 3'd5;
	localparam logic [2:0] OP_INV = 3'd6;
	localparam logic [2:0] OP_DIV = 3'd7;

	typedef struct packed {
		logic en;
		logic first;
		logic din;
	} mam_step_ctl_t;
endpackage

>>> src/mam_if.sv
// Channel interfaces of the modular arithmetic unit: request, response, config.
// Depends on nothing; widths are set by interface parameters.
interface mam_req_if #(parameter int RESIDUE_WIDTH = 16, parameter int EXPONENT_WIDTH = 63);
	logic                      valid;
	logic                      ready;
	logic [2:0]                opcode;
	logic [RESIDUE_WIDTH-1:0]  value_a;
	logic [RESIDUE_WIDTH-1:0]  value_b;
	logic [EXPONENT_WIDTH-1:0] exponent;
	logic signed [63:0]        raw_value;
	modport source (output valid, opcode, value_a, value_b, exponent, raw_value, input ready);
	modport sink (input valid, opcode, value_a, value_b, exponent, raw_value, output ready);
endinterface

interface mam_rsp_if #(parameter int RESIDUE_WIDTH = 16);
	logic                     valid;
	logic                     ready;
	logic [RESIDUE_WIDTH-1:0] result;
	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

interface mam_cfg_if #(parameter int RESIDUE_WIDTH = 16);
	logic                     valid;
	logic                     ready;
	logic [RESIDUE_WIDTH-1:0] modulus;
	modport source (output valid, modulus, input ready);
	modport sink (input valid, modulus, output ready);
endinterface

>>> src/mam_step.sv
// Serial modular double-and-add cell: acc = (2*acc + din*x) mod m per step, acc taken as zero on the first step.
// Depends on mam_pkg for the control struct.
module mam_step import mam_pkg::*; #(
	parameter int W = 16
) (
	input  logic          clk,
	input  mam_step_ctl_t ctl,
	input  logic [W-1:0]  x,
	input  logic [W-1:0]  m,
	output logic [W-1:0]  acc
);
	logic [W-1:0] acc_q;
	logic [W-1:0] base;
	logic [W:0]   dbl;
	logic [W:0]   dbl_r;
	logic [W:0]   sum;
	logic [W:0]   sum_r;

	always_comb begin
		base  = ctl.first ? '0 : acc_q;
		dbl   = {base, 1'b0};
		dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum   = {1'b0, dbl_r[W-1:0]} + (ctl.din ? {1'b0, x} : '0);
		sum_r = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= sum_r[W-1:0];
		end
	end

	assign acc = acc_q;
endmodule

>>> src/modular_arithmetic_unit.sv
// Modular arithmetic unit: top level with the sequencer and operand registers.
// Depends on mam_pkg, the channel interfaces in mam_if and mam_step.
//
// Channels: req (opcode and operands), rsp (one residue per request), cfg
// (modulus write, always ready; write it only while the unit is idle).
// req.ready is high only while no request is in work; one request is worked
// at a time. All modular products go bit serially through one double-and-add
// cell. Products per request:
//   modulus zero: none; reduce: one pass over the 64-bit raw value;
//   add, sub, neg: two; mul: three; pow, inv: two, then X squarings and k
//   multiplies, k = 1 bits walked, X = max(EXPONENT_WIDTH, W); div: one more
//   product than inv.
// The worst case is set by the square-and-multiply walk over the shared cell.
// The result sits in an output register; a new request is accepted while it
// waits, and a finished result waits in the sequencer if rsp stalls.
// Reset clears the sequencer and output valid and sets the modulus to 10007.
module modular_arithmetic_unit import mam_pkg::*; #(
	parameter int RESIDUE_WIDTH  = 16,
	parameter int EXPONENT_WIDTH = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	mam_req_if.sink    req,
	mam_rsp_if.source  rsp,
	mam_cfg_if.sink    cfg
);
	localparam int W   = RESIDUE_WIDTH;
	localparam int XW  = (EXPONENT_WIDTH > W) ? EXPONENT_WIDTH : W;
	localparam int EBW = (XW > 1) ? $clog2(XW) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_NEXT = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	localparam logic [2:0] P_RR = 3'd0;
	localparam logic [2:0] P_RA = 3'd1;
	localparam logic [2:0] P_RB = 3'd2;
	localparam logic [2:0] P_SQ = 3'd3;
	localparam logic [2:0] P_MB = 3'd4;
	localparam logic [2:0] P_FM = 3'd5;

	logic [1:0]           st_q;
	logic [2:0]           ph_q;
	logic [2:0]           op_q;
	logic [W-1:0]         mod_q;
	logic [W-1:0]         a_q;
	logic [W-1:0]         b_q;
	logic [W-1:0]         base_q;
	logic [W-1:0]         x_q;
	logic [W-1:0]         res_q;
	logic [W-1:0]         out_q;
	logic                 ov_q;
	logic                 neg_q;
	logic                 first_q;
	logic [XW-1:0]        e_q;
	logic [EBW-1:0]       ecnt_q;
	logic [6:0]           cnt_q;
	logic [RAW_WIDTH-1:0] ser_q;

	mam_step_ctl_t ctl;
	logic [W-1:0]  acc;
	logic [W-1:0]  one;
	logic [W:0]    add_s;
	logic [W:0]    sub_s;
	logic [W-1:0]  add_r;
	logic [W-1:0]  sub_r;
	logic [W-1:0]  neg_r;
	logic [W-1:0]  fermat;
	logic          adv;

	always_comb begin
		one    = (mod_q == W'(1)) ? '0 : W'(1);
		add_s  = {1'b0, a_q} + {1'b0, acc};
		add_r  = (add_s >= {1'b0, mod_q}) ? W'(add_s - {1'b0, mod_q}) : add_s[W-1:0];
		sub_s  = {1'b0, a_q} + ({1'b0, mod_q} - {1'b0, acc});
		sub_r  = (sub_s >= {1'b0, mod_q}) ? W'(sub_s - {1'b0, mod_q}) : sub_s[W-1:0];
		neg_r  = (a_q == '0) ? '0 : mod_q - a_q;
		fermat = (mod_q >= W'(2)) ? mod_q - W'(2) : '0;
		adv    = (ph_q == P_MB) || (ph_q == P_SQ && !e_q[XW-1]);
		ctl.en    = (st_q == S_RUN);
		ctl.first = first_q;
		ctl.din   = ser_q[RAW_WIDTH-1];
	end

	mam_step #(.W(W)) u_step (
		.clk (clk),
		.ctl (ctl),
		.x   (x_q),
		.m   (mod_q),
		.acc (acc)
	);

	assign req.ready  = (st_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = ov_q;
	assign rsp.result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			ov_q  <= 1'b0;
			mod_q <= W'(MOD_RESET);
		end else begin
			if (cfg.valid) begin
				mod_q <= cfg.modulus;
			end
			if (ov_q && rsp.ready && st_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.opcode;
						a_q     <= req.value_a;
						b_q     <= req.value_b;
						e_q     <= XW'(req.exponent);
						neg_q   <= req.raw_value[63];
						first_q <= 1'b1;
						x_q     <= one;
						if (mod_q == '0) begin
							res_q <= '0;
							st_q  <= S_OUT;
						end else if (req.opcode == OP_RED) begin
							ser_q <= req.raw_value[63] ? 64'd0 - req.raw_value : req.raw_value;
							cnt_q <= 7'd64;
							ph_q  <= P_RR;
							st_q  <= S_RUN;
						end else begin
							ser_q <= {req.value_a, {(RAW_WIDTH-W){1'b0}}};
							cnt_q <= 7'(W);
							ph_q  <= P_RA;
							st_q  <= S_RUN;
						end
					end
				end
				S_RUN: begin
					ser_q   <= ser_q << 1;
					first_q <= 1'b0;
					cnt_q   <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					first_q <= 1'b1;
					cnt_q   <= 7'(W);
					case (ph_q)
						P_RR: begin
							res_q <= (neg_q && acc != '0) ? mod_q - acc : acc;
							st_q  <= S_OUT;
						end
						P_RA: begin
							a_q   <= acc;
							ser_q <= {b_q, {(RAW_WIDTH-W){1'b0}}};
							x_q   <= one;
							ph_q  <= P_RB;
							st_q  <= S_RUN;
						end
						P_RB: begin
							b_q <= acc;
							case (op_q)
								OP_ADD: begin
									res_q <= add_r;
									st_q  <= S_OUT;
								end
								OP_SUB: begin
									res_q <= sub_r;
									st_q  <= S_OUT;
								end
								OP_NEG: begin
									res_q <= neg_r;
									st_q  <= S_OUT;
								end
								OP_MUL: begin
									x_q   <= a_q;
									ser_q <= {acc, {(RAW_WIDTH-W){1'b0}}};
									ph_q  <= P_FM;
									st_q  <= S_RUN;
								end
								default: begin
									base_q <= (op_q == OP_DIV) ? acc : a_q;
									if (op_q != OP_POW) begin
										e_q <= XW'(fermat);
									end
									ecnt_q <= EBW'(XW-1);
									x_q    <= one;
									ser_q  <= {one, {(RAW_WIDTH-W){1'b0}}};
									ph_q   <= P_SQ;
									st_q   <= S_RUN;
								end
							endcase
						end
						P_SQ, P_MB: begin
							if (!adv) begin
								x_q   <= base_q;
								ser_q <= {acc, {(RAW_WIDTH-W){1'b0}}};
								ph_q  <= P_MB;
								st_q  <= S_RUN;
							end else begin
								e_q <= e_q << 1;
								ser_q <= {acc, {(RAW_WIDTH-W){1'b0}}};
								if (ecnt_q == '0) begin
									if (op_q == OP_DIV) begin
										x_q  <= a_q;
										ph_q <= P_FM;
										st_q <= S_RUN;
									end else begin
										res_q <= acc;
										st_q  <= S_OUT;
									end
								end else begin
									ecnt_q <= ecnt_q - EBW'(1);
									x_q    <= acc;
									ph_q   <= P_SQ;
									st_q   <= S_RUN;
								end
							end
						end
						default: begin
							res_q <= acc;
							st_q  <= S_OUT;
						end
					endcase
				end
				default: begin
					if (!ov_q || rsp.ready) begin
						ov_q  <= 1'b1;
						out_q <= res_q;
						st_q  <= S_IDLE;
					end
				end
			endcase
		end
	end

`ifndef SYNTH
	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && req.valid && mod_q == '0) |=> st_q == S_OUT)
		else $error("zero modulus did not bypass the datapath");
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (mod_q == '0 || out_q < mod_q))
		else $error("result not below modulus");
	a_run_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_RUN |-> cnt_q != 7'd0)
		else $error("serial count underflow");
`endif
endmodule
